// ===== rtl/psa_pkg.sv =====
// psa_pkg: shared types and constants of the page span allocator
// used by psa_ctrl, psa_dp and page_span_allocator; no dependencies
`default_nettype none
package psa_pkg;

    localparam int START_W = 16;
    localparam int LEN_W   = 17;
    localparam int STAMP_W = 32;
    localparam int STAT_W  = 3;
    // table word: {stamp, mapped, free, length, start}
    localparam int WORD_W  = STAMP_W + 2 + LEN_W + START_W;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_OOP     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ZERO    = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_WR_TAIL,
        ST_WR_MAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic decide;
        logic wr_tail;
        logic wr_main;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_zero;
        logic scan_done;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/page_span_allocator.sv =====
// page_span_allocator: top level, joins controller and datapath
// depends on psa_pkg, psa_ctrl, psa_dp (and psa_ram through psa_dp)
//
// Usage:
//  - input channel i_s_*: one word per request; tuser carries the opcode
//    (allocate or free), tdata carries page count and start page
//  - output channel o_m_*: exactly one result word per request, in order
//  - config channel i_cfg_*: writes the pool page limit; always ready,
//    write only while no request is in flight
//  - a request makes one full pass over the span table through its single read
//    port, then passes the decide, tail write and main write states before its
//    result is loaded; a zero count request skips the scan, decide and writes
//  - throughput: one request at a time, next accepted the cycle after its
//    result is loaded into the output register
//  - if the receiver stalls, the result waits in the output register and the
//    block holds before loading the next result
//  - reset: span table empty, bump pointer and stamp zero, limit 65536
`default_nettype none
module page_span_allocator
    import psa_pkg::*;
#(
    parameter int TOTAL_PAGES = 65536,
    parameter int MAX_SPANS   = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // page_count[16:0], page_addr[32:17], zeros
    input  wire logic        i_s_tuser,   // opcode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // status[2:0], page_addr_res[18:3], merged[19]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [16:0] i_cfg_data
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic [STAT_W-1:0]  w_status;
    logic [START_W-1:0] w_addr_res;
    logic               w_merged;

    assign o_cfg_ready = 1'b1;

    psa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    psa_dp #(
        .TOTAL_PAGES(TOTAL_PAGES),
        .MAX_SPANS  (MAX_SPANS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_opcode       (i_s_tuser),
        .i_page_count   (i_s_tdata[16:0]),
        .i_page_addr    (i_s_tdata[32:17]),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_status       (w_status),
        .o_page_addr_res(w_addr_res),
        .o_merged       (w_merged)
    );

    assign o_m_tdata = {4'b0000, w_merged, w_addr_res, w_status};
endmodule
`default_nettype wire

// ===== rtl/psa_ram.sv =====
// psa_ram: generic single write, single read RAM with registered read data
// no dependencies
`default_nettype none
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/psa_ctrl.sv =====
// psa_ctrl: sequencing state machine of the page span allocator
// depends on psa_pkg; drives psa_dp through t_cmd, watches t_sts
`default_nettype none
module psa_ctrl
    import psa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = i_sts.in_zero ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE:  n_state = ST_WR_TAIL;
            ST_WR_TAIL: n_state = ST_WR_MAIN;
            ST_WR_MAIN: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.start = i_s_tvalid;
            end
            ST_DECIDE:  o_cmd.decide   = 1'b1;
            ST_WR_TAIL: o_cmd.wr_tail  = 1'b1;
            ST_WR_MAIN: o_cmd.wr_main  = 1'b1;
            ST_OUT:     o_cmd.load_out = !i_sts.out_busy;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.scan_done |-> r_state == ST_SCAN)
        else $error("scan done outside scan");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_SCAN || r_state == ST_OUT))
        else $error("bad state after start");
`endif
endmodule
`default_nettype wire

// ===== rtl/psa_dp.sv =====
// psa_dp: span table, scan logic, bump pointer and result register
// depends on psa_pkg and psa_ram; controlled by psa_ctrl
`default_nettype none
module psa_dp
    import psa_pkg::*;
#(
    parameter int TOTAL_PAGES = 65536,
    parameter int MAX_SPANS   = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic               i_opcode,
    input  wire logic [LEN_W-1:0]   i_page_count,
    input  wire logic [START_W-1:0] i_page_addr,
    input  wire logic               i_cfg_we,
    input  wire logic [LEN_W-1:0]   i_cfg_data,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [STAT_W-1:0]       o_status,
    output logic [START_W-1:0]      o_page_addr_res,
    output logic                    o_merged
);
    localparam int IW = $clog2(MAX_SPANS);
    localparam int LIM_CAP = (TOTAL_PAGES < 65536) ? TOTAL_PAGES : 65536;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SPANS - 1);

    logic [LEN_W-1:0]   r_limit;
    logic [LEN_W-1:0]   r_fp;
    logic [STAMP_W-1:0] r_stamp;
    logic [MAX_SPANS-1:0] r_valid;

    logic               r_op;
    logic [LEN_W-1:0]   r_count;
    logic [START_W-1:0] r_addr;
    logic [LEN_W:0]     w_nxt;
    logic               w_nxt_ok;

    logic               r_issue;
    logic [IW-1:0]      r_rd_idx;
    logic               r_chk_vld;
    logic [IW-1:0]      r_chk_idx;
    logic [WORD_W-1:0]  w_rdata;

    logic [START_W-1:0] w_e_start;
    logic [LEN_W-1:0]   w_e_len;
    logic               w_e_free, w_e_map, w_e_vld;
    logic [STAMP_W-1:0] w_e_stamp;

    logic               r_emp_found;
    logic [IW-1:0]      r_emp_idx;
    logic               r_b_found;
    logic [IW-1:0]      r_b_idx;
    logic [LEN_W-1:0]   r_b_len;
    logic [START_W-1:0] r_b_start;
    logic [STAMP_W-1:0] r_b_stamp;
    logic               r_s_found;
    logic [IW-1:0]      r_s_idx;
    logic [LEN_W-1:0]   r_s_len;
    logic               r_s_free;
    logic               r_n_found;
    logic [IW-1:0]      r_n_idx;
    logic [LEN_W-1:0]   r_n_len;
    logic               r_n_free;

    logic               r_do_tail, r_do_main;
    logic [IW-1:0]      r_tail_idx, r_main_idx;
    logic [WORD_W-1:0]  r_tail_word, r_main_word;
    logic [STAT_W-1:0]  r_status;
    logic [START_W-1:0] r_res_addr;
    logic               r_merged;

    logic               r_out_valid;
    logic [STAT_W-1:0]  r_o_status;
    logic [START_W-1:0] r_o_addr;
    logic               r_o_merged;

    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic [WORD_W-1:0]  w_wdata;

    // decision logic
    logic [LEN_W-1:0]   w_eff;
    logic               w_oop;
    logic [LEN_W:0]     w_sum;
    logic [LEN_W-1:0]   w_sum_sat;
    logic               w_merge;

    assign w_nxt    = {2'b00, r_addr} + {1'b0, r_count};
    assign w_nxt_ok = w_nxt <= (LEN_W+1)'(16'hFFFF);

    assign {w_e_stamp, w_e_map, w_e_free, w_e_len, w_e_start} = w_rdata;
    assign w_e_vld = r_valid[r_chk_idx];

    assign w_eff = (r_limit > LEN_W'(LIM_CAP)) ? LEN_W'(LIM_CAP) : r_limit;
    assign w_oop = (r_fp > w_eff) || (r_count > (w_eff - r_fp));
    assign w_sum = {1'b0, r_s_len} + {1'b0, r_n_len};
    assign w_sum_sat = w_sum[LEN_W] ? LEN_MAX : w_sum[LEN_W-1:0];
    assign w_merge = r_n_found && r_n_free && w_nxt_ok;

    assign w_we    = (i_cmd.wr_tail && r_do_tail) || (i_cmd.wr_main && r_do_main);
    assign w_waddr = i_cmd.wr_tail ? r_tail_idx : r_main_idx;
    assign w_wdata = i_cmd.wr_tail ? r_tail_word : r_main_word;

    psa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_SPANS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_rd_idx),
        .o_rdata(w_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LEN_W'(65536);
            r_fp        <= '0;
            r_stamp     <= '0;
            r_valid     <= '0;
            r_issue     <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_do_tail   <= 1'b0;
            r_do_main   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_chk_vld <= r_issue;
            if (i_cmd.start) begin
                r_issue <= (i_page_count != '0);
            end else if (r_issue && r_rd_idx == LAST_IDX) begin
                r_issue <= 1'b0;
            end
            if (i_cmd.start) begin
                r_do_tail <= 1'b0;
                r_do_main <= 1'b0;
            end
            if (i_cmd.decide) begin
                r_do_tail <= 1'b0;
                r_do_main <= 1'b0;
                if (r_op == OP_ALLOC) begin
                    if (r_b_found) begin
                        if (r_b_len > r_count) begin
                            if (r_emp_found) begin
                                r_do_tail <= 1'b1;
                                r_do_main <= 1'b1;
                                r_valid[r_emp_idx] <= 1'b1;
                                r_stamp <= r_stamp + 1'b1;
                            end
                        end else begin
                            r_do_main <= 1'b1;
                        end
                    end else if (!w_oop && r_emp_found) begin
                        r_do_main <= 1'b1;
                        r_valid[r_emp_idx] <= 1'b1;
                        r_fp <= r_fp + r_count;
                    end
                end else if (r_s_found && !r_s_free) begin
                    r_do_main <= 1'b1;
                    r_stamp <= r_stamp + 1'b1;
                    if (w_merge) begin
                        r_valid[r_n_idx] <= 1'b0;
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: request, scan captures, decision, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op        <= i_opcode;
            r_count     <= i_page_count;
            r_addr      <= i_page_addr;
            r_rd_idx    <= '0;
            r_emp_found <= 1'b0;
            r_b_found   <= 1'b0;
            r_s_found   <= 1'b0;
            r_n_found   <= 1'b0;
            r_status    <= STAT_ZERO;
            r_res_addr  <= '0;
            r_merged    <= 1'b0;
        end else begin
            if (r_issue && r_rd_idx != LAST_IDX) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
        r_chk_idx <= r_rd_idx;

        if (r_chk_vld) begin
            if (!w_e_vld && !r_emp_found) begin
                r_emp_found <= 1'b1;
                r_emp_idx   <= r_chk_idx;
            end
            if (w_e_vld && w_e_free && w_e_len >= r_count &&
                (!r_b_found || w_e_len < r_b_len ||
                 (w_e_len == r_b_len && w_e_stamp > r_b_stamp))) begin
                r_b_found <= 1'b1;
                r_b_idx   <= r_chk_idx;
                r_b_len   <= w_e_len;
                r_b_start <= w_e_start;
                r_b_stamp <= w_e_stamp;
            end
            if (w_e_vld && w_e_map && w_e_start == r_addr && !r_s_found) begin
                r_s_found <= 1'b1;
                r_s_idx   <= r_chk_idx;
                r_s_len   <= w_e_len;
                r_s_free  <= w_e_free;
            end
            if (w_e_vld && w_e_map && w_nxt_ok && w_e_start == w_nxt[START_W-1:0] &&
                !r_n_found) begin
                r_n_found <= 1'b1;
                r_n_idx   <= r_chk_idx;
                r_n_len   <= w_e_len;
                r_n_free  <= w_e_free;
            end
        end

        if (i_cmd.decide) begin
            r_status   <= STAT_OK;
            r_res_addr <= '0;
            r_merged   <= 1'b0;
            r_tail_idx <= r_emp_idx;
            r_tail_word <= {r_stamp, 1'b0, 1'b1, r_b_len - r_count,
                            r_b_start + r_count[START_W-1:0]};
            if (r_op == OP_ALLOC) begin
                if (r_b_found) begin
                    r_main_idx  <= r_b_idx;
                    r_main_word <= {r_b_stamp, 1'b1, 1'b0, r_count, r_b_start};
                    if (r_b_len > r_count && !r_emp_found) begin
                        r_status <= STAT_FULL;
                    end else begin
                        r_res_addr <= r_b_start;
                    end
                end else begin
                    r_main_idx  <= r_emp_idx;
                    r_main_word <= {{STAMP_W{1'b0}}, 1'b1, 1'b0, r_count,
                                    r_fp[START_W-1:0]};
                    if (w_oop) begin
                        r_status <= STAT_OOP;
                    end else if (!r_emp_found) begin
                        r_status <= STAT_FULL;
                    end else begin
                        r_res_addr <= r_fp[START_W-1:0];
                    end
                end
            end else begin
                r_main_idx  <= r_s_idx;
                r_main_word <= {r_stamp, 1'b1, 1'b1,
                                w_merge ? w_sum_sat : r_s_len, r_addr};
                if (!r_s_found || r_s_free) begin
                    r_status <= STAT_UNKNOWN;
                end else begin
                    r_merged <= w_merge;
                end
            end
        end

        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_addr   <= r_res_addr;
            r_o_merged <= r_merged;
        end
    end

    assign o_sts.in_zero   = (i_page_count == '0);
    assign o_sts.scan_done = r_chk_vld && (r_chk_idx == LAST_IDX);
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_page_addr_res = r_o_addr;
    assign o_merged        = r_o_merged;

`ifndef SYNTHESIS
    a_fp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fp <= LEN_W'(LIM_CAP))
        else $error("bump pointer beyond page space");
    a_fail_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |=> (r_status == STAT_OK) == r_do_main)
        else $error("table write on refused request");
    a_tail_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_do_tail |-> r_do_main)
        else $error("tail write without head write");
`endif
endmodule
`default_nettype wire
